// ===== src/kvt_pkg.sv =====
package kvt_pkg;

   // table geometry
   localparam int CAPACITY    = 16;
   localparam int VALUE_BYTES = 8;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (CNT_W > 5) ? CNT_W + 1 : 6;

   // port field widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;
   localparam int LEN_W   = 4;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;
   localparam int CSR_W   = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_TOO_LONG = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_MISSING  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_VALUE_LIMIT    = 1'b0,
      CSR_CAPACITY_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_RUN  = 1'b1
   } state_type;

   // one stored entry
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // search result handed from cell to cell
   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   pos;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
   } carry_type;

   // operation broadcast to every cell
   typedef struct packed {
      cmd_type            kind;
      logic               ins_ok;
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   fill;
   } op_type;

   // finished result beat
   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   pos;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } result_type;

   // keep only the low len bytes of a value word
   function automatic logic [VALUE_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [VALUE_W-1:0] m;
      m = '0;
      for (int b = 0; b < VALUE_W / 8; b++) begin
         if (LEN_W'(b) < len) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

// ===== src/kvt_if.sv =====
interface kvt_req_if;
   import kvt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                cmd;
   logic signed [KEY_W-1:0]   key;
   logic [VALUE_W-1:0]        value_word;
   logic [LEN_W-1:0]          byte_len;

   modport source (output valid, cmd, key, value_word, byte_len, input ready);
   modport sink   (input valid, cmd, key, value_word, byte_len, output ready);
endinterface

interface kvt_rsp_if;
   import kvt_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [POS_W-1:0]   entry_pos;
   logic [LEN_W-1:0]   entry_len;
   logic [VALUE_W-1:0] entry_value;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, entry_pos, entry_len, entry_value, entry_count,
                   input ready);
   modport sink   (input valid, status, entry_pos, entry_len, entry_value, entry_count,
                   output ready);
endinterface

// ===== src/kvt_cell.sv =====
module kvt_cell
   import kvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] index,
   input  op_type           op,
   input  logic             wave_in,
   input  carry_type        carry_in,
   input  entry_type        next_entry,
   output logic             wave_out,
   output carry_type        carry_out,
   output entry_type        entry
);

   logic      wave_ff;
   carry_type carry_ff;
   carry_type carry_in_w;
   entry_type entry_ff;
   entry_type entry_in;
   logic      in_range;
   logic      match;
   logic      found_here;

   // compare against the broadcast key while the wave passes this cell
   always_comb begin
      in_range   = CNT_W'(index) < op.fill;
      match      = in_range && (entry_ff.key == op.key) && !carry_in.found;
      found_here = carry_in.found || match;
   end

   // pass the earlier hit on, or put this entry on the chain
   always_comb begin
      carry_in_w = carry_in;
      if (match) begin
         carry_in_w.found = 1'b1;
         carry_in_w.pos   = index;
         carry_in_w.len   = entry_ff.len;
         carry_in_w.value = entry_ff.value;
      end
   end

   // append on insert, pull the right neighbor down on delete
   always_comb begin
      entry_in = entry_ff;
      if (wave_in) begin
         case (op.kind)
            CMD_INSERT: begin
               if (op.ins_ok && (CNT_W'(index) == op.fill)) begin
                  entry_in.key   = op.key;
                  entry_in.len   = op.len;
                  entry_in.value = op.value;
               end
            end
            CMD_DELETE: begin
               if (found_here) begin
                  entry_in = next_entry;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= 1'b0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (wave_in) begin
         carry_ff <= carry_in_w;
      end
   end

   assign wave_out  = wave_ff;
   assign carry_out = carry_ff;
   assign entry     = entry_ff;

endmodule

// ===== src/compacting_key_value_table.sv =====
// Compacting key/value table.
// Commands arrive as beats on req_bus (valid/ready): insert, delete or lookup of a
// signed 32-bit key. Each accepted beat gives exactly one beat on rsp_bus with a
// status, the hit position, length and value on a lookup, and the entry count.
// Entries live in a row of CAPACITY cells. A search wave enters cell 0 in the cycle
// after acceptance and moves one cell per cycle; the first matching cell puts its
// entry on the chain, and on delete every cell at or past the hit pulls its right
// neighbor down as the wave passes. When the wave leaves the last cell the result
// goes to the pending register; the next command is taken only after that, and the
// length of the cell row sets how long a command runs.
// A finished result waits in a pending register while an earlier one is still
// stalled on rsp_bus, so one more command may run behind a stalled beat.
// req_bus.ready is low while a command runs and while the pending register is full.
// csr_we writes value_limit (index 0) or capacity_limit (index 1).
// Reset empties the table, clears both channels and sets the limits to 8 and 16.
module compacting_key_value_table
   import kvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   kvt_req_if.sink          req_bus,
   kvt_rsp_if.source        rsp_bus
);

   logic [LEN_W-1:0] value_limit_ff;
   logic [4:0]       capacity_limit_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   state_type        state_ff;
   state_type        state_in;
   op_type           op_ff;
   status_type       ins_status_ff;
   status_type       ins_status;
   logic             start_ff;
   logic             pend_valid_ff;
   result_type       pend_ff;
   result_type       pend_in;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             req_fire;
   logic             done;
   logic             move;
   logic             too_long;
   logic             full;
   carry_type        tail;

   logic             wave_w  [0:CAPACITY];
   carry_type        carry_w [0:CAPACITY];
   entry_type        entry_w [0:CAPACITY-1];

   // width helpers for the fixed-width result fields
   function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] p);
      logic [IDX_W+POS_W-1:0] t;
      t = (IDX_W + POS_W)'(p);
      return t[POS_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_W-1:0] t;
      t = (CNT_W + COUNT_W)'(c);
      return t[COUNT_W-1:0];
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         value_limit_ff    <= LEN_W'(8);
         capacity_limit_ff <= 5'd16;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VALUE_LIMIT:    value_limit_ff    <= csr_wdata[LEN_W-1:0];
            CSR_CAPACITY_LIMIT: capacity_limit_ff <= csr_wdata[4:0];
            default:            value_limit_ff    <= value_limit_ff;
         endcase
      end
   end

   // insert checks: length first, then fullness
   always_comb begin
      too_long = (req_bus.byte_len > value_limit_ff) ||
                 (req_bus.byte_len > LEN_W'(VALUE_BYTES));
      full     = (CMP_W'(count_ff) >= CMP_W'(capacity_limit_ff)) ||
                 (CMP_W'(count_ff) >= CMP_W'(CAPACITY));
      if (too_long) begin
         ins_status = STAT_TOO_LONG;
      end else if (full) begin
         ins_status = STAT_FULL;
      end else begin
         ins_status = STAT_OK;
      end
   end

   assign req_fire = req_bus.valid && req_bus.ready;
   assign done     = wave_w[CAPACITY];
   assign tail     = carry_w[CAPACITY];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_RUN;
         S_RUN:   if (done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         S_IDLE:  req_bus.ready = !pend_valid_ff;
         S_RUN:   req_bus.ready = 1'b0;
         default: req_bus.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire;
      end
   end

   // latch the command for broadcast
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff.kind    <= cmd_type'(req_bus.cmd);
         op_ff.ins_ok  <= (cmd_type'(req_bus.cmd) == CMD_INSERT) && (ins_status == STAT_OK);
         op_ff.key     <= req_bus.key;
         op_ff.len     <= req_bus.byte_len;
         op_ff.value   <= req_bus.value_word & byte_mask(req_bus.byte_len);
         op_ff.fill    <= count_ff;
         ins_status_ff <= ins_status;
      end
   end

   // cell row
   assign wave_w[0]  = start_ff;
   assign carry_w[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type next_w;
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = entry_w[i];
      end else begin : g_mid
         assign next_w = entry_w[i+1];
      end
      kvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .index      (IDX_W'(i)),
         .op         (op_ff),
         .wave_in    (wave_w[i]),
         .carry_in   (carry_w[i]),
         .next_entry (next_w),
         .wave_out   (wave_w[i+1]),
         .carry_out  (carry_w[i+1]),
         .entry      (entry_w[i])
      );
   end

   // new count and result when the wave leaves the last cell
   always_comb begin
      count_in = count_ff;
      if (done) begin
         if (op_ff.kind == CMD_INSERT && op_ff.ins_ok) begin
            count_in = count_ff + CNT_W'(1);
         end else if (op_ff.kind == CMD_DELETE && tail.found) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      pend_in       = '0;
      pend_in.count = to_count(count_in);
      case (op_ff.kind)
         CMD_INSERT: pend_in.status = ins_status_ff;
         CMD_DELETE: pend_in.status = tail.found ? STAT_OK : STAT_MISSING;
         CMD_LOOKUP: begin
            pend_in.status = tail.found ? STAT_OK : STAT_MISSING;
            if (tail.found) begin
               pend_in.pos   = to_pos(tail.pos);
               pend_in.len   = tail.len;
               pend_in.value = tail.value;
            end
         end
         default:    pend_in.status = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // pending and output registers
   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (done) begin
            pend_valid_ff <= 1'b1;
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         pend_ff <= pend_in;
      end
      if (move) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.entry_pos   = rsp_ff.pos;
   assign rsp_bus.entry_len   = rsp_ff.len;
   assign rsp_bus.entry_value = rsp_ff.value;
   assign rsp_bus.entry_count = rsp_ff.count;

endmodule

// ===== src/kvt_checker.sv =====
module kvt_checker
   import kvt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [POS_W-1:0]   rsp_entry_pos,
   input logic [LEN_W-1:0]   rsp_entry_len,
   input logic [VALUE_W-1:0] rsp_entry_value
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result beat dropped or changed while stalled");

   // carry entry fields only on a successful beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |->
         (rsp_entry_pos == '0) && (rsp_entry_len == '0) && (rsp_entry_value == '0))
      else $error("entry fields set on a failed command");

   // stored lengths never exceed the value word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_len <= LEN_W'(VALUE_BYTES))
      else $error("entry length beyond the value word");

   // no result beat right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind compacting_key_value_table kvt_checker u_kvt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_entry_pos   (rsp_bus.entry_pos),
   .rsp_entry_len   (rsp_bus.entry_len),
   .rsp_entry_value (rsp_bus.entry_value)
);
